// ----- rtl/core/irps_pkg.sv -----
// Package for the IR pulse/space timer.
// Holds the fixed field widths, register indexes and conversion constants.
// No dependencies.
package irps_pkg;

	localparam int SAMPLE_WIDTH = 8;
	localparam int PIN_WIDTH = 3;
	localparam int BAUD_WIDTH = 22;
	localparam int CFG_ADDR_WIDTH = 1;
	localparam int CFG_DATA_WIDTH = BAUD_WIDTH;

	localparam logic [CFG_ADDR_WIDTH-1:0] REG_PIN_SELECT = 1'd0;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_BAUD_SETTING = 1'd1;

	localparam logic [PIN_WIDTH-1:0] PIN_SELECT_RESET = 3'd1;
	localparam logic [BAUD_WIDTH-1:0] BAUD_SETTING_RESET = 22'd4800;

	// One microsecond conversion factor, used as a 20-bit shift-add constant.
	localparam int MUL_BITS = 20;
	localparam logic [MUL_BITS-1:0] US_PER_SECOND = 20'd1000000;

	// The sample rate is sixteen times the baud rate.
	localparam int SPB_SHIFT = 4;
	localparam int DIVISOR_WIDTH = BAUD_WIDTH + SPB_SHIFT;

endpackage

// ----- rtl/core/irps_divider.sv -----
// Sample count to microsecond converter for the IR pulse/space timer.
// Computes count*1000000/(baud*16), clamped, with one shared adder.
// Depends on irps_pkg.
module irps_divider #(
	parameter int DURATION_WIDTH = 24,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [COUNT_WIDTH-1:0]            count,
	input  logic [irps_pkg::BAUD_WIDTH-1:0]   baud,
	output logic                              done,
	output logic [DURATION_WIDTH-1:0]         quotient
);

	localparam int DW = DURATION_WIDTH;
	localparam int DVW = irps_pkg::DIVISOR_WIDTH;
	localparam int PW = COUNT_WIDTH + irps_pkg::MUL_BITS;
	localparam int SW = DVW + DW;
	localparam int AW = (PW > SW) ? PW : SW;
	localparam int STEPS = (irps_pkg::MUL_BITS > DW) ? irps_pkg::MUL_BITS : DW;
	localparam int CNTW = $clog2(STEPS);
	localparam int MIDXW = $clog2(irps_pkg::MUL_BITS);

	typedef enum logic [1:0] {
		D_IDLE,
		D_MUL,
		D_CMP,
		D_DIV
	} dstate_t;

	dstate_t                   state_q;
	logic [COUNT_WIDTH-1:0]    mcand_q;
	logic [DVW-1:0]            divisor_q;
	logic [AW-1:0]             acc_q;
	logic [DVW-1:0]            rem_q;
	logic [DW-1:0]             quo_q;
	logic [CNTW-1:0]           cnt_q;
	logic                      done_q;

	logic [AW-1:0]             alu_a;
	logic [AW-1:0]             alu_b;
	logic                      alu_sub;
	logic [AW:0]               alu_sum;
	logic                      alu_carry;
	logic [DVW:0]              trial;

	assign trial = {rem_q, acc_q[DW-1]};

	always_comb begin
		alu_a = acc_q;
		alu_b = '0;
		alu_sub = 1'b0;
		case (state_q)
			D_MUL: begin
				alu_a = acc_q << 1;
				alu_b = irps_pkg::US_PER_SECOND[cnt_q[MIDXW-1:0]] ? AW'(mcand_q) : '0;
			end
			D_CMP: begin
				alu_b = AW'({divisor_q, {DW{1'b0}}});
				alu_sub = 1'b1;
			end
			D_DIV: begin
				alu_a = AW'(trial);
				alu_b = AW'(divisor_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = acc_q;
			end
		endcase
		alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
		alu_carry = alu_sum[AW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						mcand_q <= count;
						divisor_q <= {baud, {irps_pkg::SPB_SHIFT{1'b0}}};
						acc_q <= '0;
						cnt_q <= CNTW'(irps_pkg::MUL_BITS - 1);
						if (baud == '0) begin
							quo_q <= '1;
							done_q <= 1'b1;
						end else begin
							state_q <= D_MUL;
						end
					end
				end
				D_MUL: begin
					acc_q <= alu_sum[AW-1:0];
					if (cnt_q == '0) begin
						state_q <= D_CMP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				D_CMP: begin
					if (alu_carry) begin
						quo_q <= '1;
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						rem_q <= acc_q[SW-1:DW];
						cnt_q <= CNTW'(DW - 1);
						state_q <= D_DIV;
					end
				end
				D_DIV: begin
					if (alu_carry) begin
						rem_q <= alu_sum[DVW-1:0];
					end else begin
						rem_q <= trial[DVW-1:0];
					end
					quo_q <= {quo_q[DW-2:0], alu_carry};
					acc_q <= acc_q << 1;
					if (cnt_q == '0) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/ir_pulse_space_timer.sv -----
// Top level of the IR pulse/space timer: level tracking, sample counter,
// configuration registers and result register.
// Depends on irps_pkg and irps_divider.
//
//  Channel  | Signals                               | Direction
//  ---------+---------------------------------------+----------
//  config   | cfg_we, cfg_addr, cfg_wdata           | in
//  sample   | sample_valid/ready, sample_byte       | in
//  result   | result_valid/ready, duration_us,      | out
//           | is_pulse                              |
//
// A sample without a level change is accepted at once and the next can follow straight after.
// A sample with a level change holds off the next beat while 20 shift-add steps, one range
// compare and DURATION_WIDTH restoring steps run through one adder, and the result register
// is then loaded before the next sample is accepted.
// An overflowing quotient ends after the compare; a zero baud setting skips all steps.
// Reset clears the level, the count and the result register.
// A full result register stalls the block until the waiting beat is taken downstream.
module ir_pulse_space_timer #(
	parameter int DURATION_WIDTH = 24,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [irps_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
	input  logic [irps_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [irps_pkg::SAMPLE_WIDTH-1:0]    sample_byte,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [DURATION_WIDTH-1:0]            duration_us,
	output logic                                 is_pulse
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WAIT
	} state_t;

	state_t                              state_q;
	logic [irps_pkg::PIN_WIDTH-1:0]      pin_select_q;
	logic [irps_pkg::BAUD_WIDTH-1:0]     baud_setting_q;
	logic                                prev_level_q;
	logic                                known_q;
	logic [COUNT_WIDTH-1:0]              count_q;
	logic                                pulse_q;
	logic                                out_valid_q;
	logic [DURATION_WIDTH-1:0]           duration_q;
	logic                                is_pulse_q;

	logic                                level;
	logic                                change;
	logic [COUNT_WIDTH-1:0]              count_next;
	logic                                div_start;
	logic                                div_done;
	logic [DURATION_WIDTH-1:0]           div_quotient;
	logic                                out_free;
	logic                                out_load;

	assign level = sample_byte[pin_select_q];
	assign change = !known_q || (level != prev_level_q);
	assign count_next = (count_q == '1) ? count_q : count_q + 1'b1;
	assign sample_ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_IDLE) && sample_valid && change;
	assign out_free = !out_valid_q || result_ready;
	assign out_load = (((state_q == ST_CALC) && div_done) || (state_q == ST_WAIT)) && out_free;

	irps_divider #(
		.DURATION_WIDTH(DURATION_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.count(count_next),
		.baud(baud_setting_q),
		.done(div_done),
		.quotient(div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pin_select_q <= irps_pkg::PIN_SELECT_RESET;
			baud_setting_q <= irps_pkg::BAUD_SETTING_RESET;
			prev_level_q <= 1'b0;
			known_q <= 1'b0;
			count_q <= '0;
			pulse_q <= 1'b0;
			out_valid_q <= 1'b0;
			duration_q <= '0;
			is_pulse_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					irps_pkg::REG_PIN_SELECT: pin_select_q <= cfg_wdata[irps_pkg::PIN_WIDTH-1:0];
					irps_pkg::REG_BAUD_SETTING: baud_setting_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				duration_q <= div_quotient;
				is_pulse_q <= pulse_q;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						if (change) begin
							prev_level_q <= level;
							known_q <= 1'b1;
							count_q <= '0;
							pulse_q <= level;
							state_q <= ST_CALC;
						end else begin
							count_q <= count_next;
						end
					end
				end
				ST_CALC: begin
					if (div_done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign duration_us = duration_q;
	assign is_pulse = is_pulse_q;

endmodule
